/* rtl/core/rwlt_pkg.sv */
package rwlt_pkg;

    localparam int TXN_W = 16;
    localparam int ENT_W = 19;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    localparam logic [1:0] ST_ACTIVE   = 2'd0;
    localparam logic [1:0] ST_WAIT     = 2'd1;
    localparam logic [1:0] ST_OBSOLETE = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] lock_key;
        logic [15:0] txn_id;
        logic        exclusive;
    } t_req;

    typedef struct packed {
        logic [1:0] lock_state;
        logic [1:0] status;
        logic [3:0] grant_count;
    } t_rsp;

    // queue entry: state in the top bits, mode, then txn
    typedef struct packed {
        logic [1:0]  state;
        logic        mode;
        logic [15:0] txn;
    } t_ent;

endpackage

/* rtl/core/reader_writer_lock_table_core.sv */
// Reader/writer lock table. Each key maps to bucket (key mod NUM_BUCKETS),
// and each bucket holds an ordered queue of up to QUEUE_DEPTH requests in a
// single-port-write entry memory; fill counts live in a second memory. After
// reset the block clears every fill count in one pass, with ready low. One
// operation is handled at a time. An operation reads the fill count, then
// walks the bucket one entry per cycle through the entry memory: an acquire
// reads fill entries, a release and a check read up to fill entries, then a
// release with no active entry before the released one makes a second
// read-modify-write pass over the entries after the released one. An
// acquire on a full bucket first compacts obsolete entries with one read
// and up to one write per entry. The result moves into an output register,
// so the next request is taken while it waits; a further result holds the
// block until the waiting one is taken.
module reader_writer_lock_table_core
    import rwlt_pkg::*;
#(
    parameter int NUM_BUCKETS = 256,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int EAW = $clog2(NUM_BUCKETS * QUEUE_DEPTH);
    localparam int EA = (EAW > 0) ? EAW : 1;
    localparam int EDEPTH = (EAW > 0) ? NUM_BUCKETS * QUEUE_DEPTH : 2;
    localparam int FDEPTH = (NUM_BUCKETS > 1) ? NUM_BUCKETS : 2;
    localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FRD   = 10'b0000000010,
        S_FGET  = 10'b0000000100,
        S_CMP   = 10'b0000001000,
        S_SCAN  = 10'b0000010000,
        S_REL   = 10'b0000100000,
        S_APP   = 10'b0001000000,
        S_FWB   = 10'b0010000000,
        S_OUT   = 10'b0100000000,
        S_CLR   = 10'b1000000000
    } t_state;

    t_state r_st, n_st;
    t_req   r_req, n_req;
    t_rsp   r_rsp, n_rsp;
    t_rsp   r_orsp, n_orsp;             // output register
    logic [FW-1:0] r_fill, n_fill;      // fill count of the bucket
    logic [FW-1:0] r_idx, n_idx;        // read index
    logic [FW-1:0] r_wr, n_wr;          // compaction write index
    logic          r_pend, n_pend;      // read issued last cycle
    logic [FW-1:0] r_pidx, n_pidx;      // index of the pending read
    logic          r_hit, n_hit;        // conflict seen / active before
    logic          r_shared, n_shared;  // shared entry granted
    logic [3:0]    r_grants, n_grants;
    logic [BW:0]   r_clr, n_clr;        // fill clearing pass
    logic          r_ovalid, n_ovalid;

    logic [BW-1:0] bucket;
    logic          e_we, f_we;
    logic [EA-1:0] e_waddr, e_raddr;
    t_ent          e_wdata, e_rdata;
    logic [BW-1:0] f_waddr;
    logic [FW-1:0] f_wdata, f_rdata;

    if (NUM_BUCKETS > 1) begin : g_bk
        assign bucket = BW'(r_req.lock_key % NUM_BUCKETS);
    end else begin : g_bk1
        assign bucket = '0;
    end

    function automatic logic [EA-1:0] eaddr(input logic [BW-1:0] b,
                                            input logic [FW-1:0] i);
        logic [EA+FW:0] a;
        a = (EA+FW+1)'(b) * (EA+FW+1)'(QUEUE_DEPTH) + (EA+FW+1)'(i);
        return a[EA-1:0];
    endfunction

    rwlt_ram #(.WIDTH(ENT_W), .DEPTH(EDEPTH)) u_ent (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    rwlt_ram #(.WIDTH(FW), .DEPTH(FDEPTH)) u_fill (
        .i_clk(i_clk), .i_we(f_we), .i_waddr($clog2(FDEPTH)'(f_waddr)),
        .i_wdata(f_wdata), .i_raddr($clog2(FDEPTH)'(bucket)), .o_rdata(f_rdata)
    );

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_orsp;

    // sequencer: fill clear, fill fetch, compaction, bucket walks, append, write back, output
    always_comb begin
        t_ent e;
        n_st = r_st; n_req = r_req; n_rsp = r_rsp; n_fill = r_fill;
        n_idx = r_idx; n_wr = r_wr; n_pend = 1'b0; n_pidx = r_pidx;
        n_hit = r_hit; n_shared = r_shared; n_grants = r_grants;
        n_clr = r_clr; n_ovalid = r_ovalid; n_orsp = r_orsp;
        e_we = 1'b0; e_waddr = eaddr(bucket, r_pidx); e_wdata = e_rdata;
        e_raddr = eaddr(bucket, r_idx);
        f_we = 1'b0; f_waddr = bucket; f_wdata = r_fill;
        e = e_rdata;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_st)
            S_CLR: begin
                f_we = 1'b1; f_waddr = r_clr[BW-1:0]; f_wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == (BW+1)'(NUM_BUCKETS - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_req = i_req;
                    n_st  = S_FRD;
                end
            end
            S_FRD: n_st = S_FGET;
            S_FGET: begin
                n_fill = (f_rdata > DEPTH_F) ? DEPTH_F : f_rdata;
                n_idx = '0; n_wr = '0; n_hit = 1'b0; n_shared = 1'b0;
                n_grants = '0;
                n_rsp = '{lock_state: ST_NONE, status: STS_NOTFOUND, grant_count: '0};
                if (r_req.operation == OP_ACQUIRE && n_fill >= DEPTH_F) begin
                    n_st = S_CMP;
                end else if (r_req.operation == OP_ACQUIRE
                          || r_req.operation == OP_RELEASE
                          || r_req.operation == OP_CHECK) begin
                    n_st = S_SCAN;
                end else begin
                    n_st = S_OUT;
                end
            end
            // squeeze obsolete entries out, keeping order
            S_CMP: begin
                if (r_pend) begin
                    if (e.state != ST_OBSOLETE) begin
                        e_we = 1'b1; e_waddr = eaddr(bucket, r_wr);
                        n_wr = r_wr + 1'b1;
                    end
                end
                if (r_idx < r_fill) begin
                    n_pend = 1'b1; n_pidx = r_idx; n_idx = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_fill = r_wr; n_idx = '0;
                    if (r_wr >= DEPTH_F) begin
                        n_rsp.status = STS_FULL;
                        n_st = S_FWB;
                    end else begin
                        n_st = S_SCAN;
                    end
                end
            end
            // first walk: conflict, first live match, first match
            S_SCAN: begin
                if (r_pend) begin
                    case (r_req.operation)
                        OP_ACQUIRE: begin
                            if (e.state != ST_OBSOLETE
                                && (e.mode || r_req.exclusive)) begin
                                n_hit = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            if (e.state != ST_OBSOLETE) begin
                                if (e.txn == r_req.txn_id) begin
                                    e_we = 1'b1;
                                    e_wdata.state = ST_OBSOLETE;
                                    n_rsp.lock_state = ST_OBSOLETE;
                                    n_rsp.status = STS_OK;
                                    n_idx = r_pidx + 1'b1;
                                    n_st = r_hit ? S_FWB : S_REL;
                                end else if (e.state == ST_ACTIVE) begin
                                    n_hit = 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (e.txn == r_req.txn_id) begin
                                n_rsp.lock_state = e.state;
                                n_rsp.status = STS_OK;
                                n_st = S_FWB;
                            end
                        end
                    endcase
                end
                if (n_st == S_SCAN) begin
                    if (r_idx < r_fill) begin
                        n_pend = 1'b1; n_pidx = r_idx; n_idx = r_idx + 1'b1;
                    end else if (!r_pend) begin
                        n_st = (r_req.operation == OP_ACQUIRE) ? S_APP : S_FWB;
                    end
                end
            end
            // grant walk after a release
            S_REL: begin
                if (r_pend && e.state != ST_OBSOLETE) begin
                    if (e.mode) begin
                        if (!r_shared) begin
                            if (e.state == ST_WAIT) begin
                                n_grants = r_grants + 1'b1;
                            end
                            e_we = 1'b1; e_wdata.state = ST_ACTIVE;
                        end
                        n_st = S_FWB;
                    end else begin
                        if (e.state == ST_WAIT) begin
                            n_grants = r_grants + 1'b1;
                        end
                        e_we = 1'b1; e_wdata.state = ST_ACTIVE;
                        n_shared = 1'b1;
                    end
                end
                if (n_st == S_REL) begin
                    if (r_idx < r_fill) begin
                        n_pend = 1'b1; n_pidx = r_idx; n_idx = r_idx + 1'b1;
                    end else if (!r_pend) begin
                        n_st = S_FWB;
                    end
                end
                n_rsp.grant_count = n_grants;
            end
            S_APP: begin
                e_we = 1'b1; e_waddr = eaddr(bucket, r_fill);
                e_wdata = '{state: r_hit ? ST_WAIT : ST_ACTIVE,
                            mode: r_req.exclusive, txn: r_req.txn_id};
                n_rsp.lock_state = e_wdata.state;
                n_rsp.status = STS_OK;
                n_fill = r_fill + 1'b1;
                n_st = S_FWB;
            end
            S_FWB: begin
                f_we = 1'b1;
                n_st = S_OUT;
            end
            // hold until the output register is free
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_orsp = r_rsp;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // hold control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_st <= n_st;
            r_clr <= n_clr;
            r_ovalid <= n_ovalid;
            r_pend <= n_pend;
        end
        r_req <= n_req; r_rsp <= n_rsp; r_fill <= n_fill; r_idx <= n_idx;
        r_wr <= n_wr; r_pidx <= n_pidx; r_hit <= n_hit;
        r_shared <= n_shared; r_grants <= n_grants; r_orsp <= n_orsp;
    end

endmodule

/* rtl/core/rwlt_ram.sv */
module rwlt_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/reader_writer_lock_table_core_tb.sv */
`timescale 1ns / 100ps

module reader_writer_lock_table_core_tb;
    import rwlt_pkg::*;

    localparam int NB = 256;
    localparam int QD = 8;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_req i_req;
    logic o_valid;
    logic i_ready;
    t_rsp o_rsp;

    reader_writer_lock_table_core #(.NUM_BUCKETS(NB), .QUEUE_DEPTH(QD)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    // lock table shadow
    t_ent   tbl_ent [NB][QD];
    int     tbl_fill [NB];

    t_req   pending_reqs[$];
    t_rsp   expected_rsps[$];
    int     errors;
    int     n_sent, n_checked, n_full, n_grants, n_waits;
    bit     stim_done;
    int     stall_hold;
    int     idle_cycles;
    int     burst_left, gap_left;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // compute response of one operation and update the table
    function automatic t_rsp lock_table_apply(input t_req r);
        t_rsp res;
        int b, f, w, pos, act_before, shared_passed;
        logic [1:0] st;
        t_ent e;
        b = r.lock_key % NB;
        f = tbl_fill[b];
        res.lock_state = ST_NONE;
        res.status = STS_NOTFOUND;
        res.grant_count = '0;
        if (r.operation == OP_ACQUIRE) begin
            // squeeze out obsolete entries when full
            if (f >= QD) begin
                w = 0;
                for (int i = 0; i < f; i++) begin
                    if (tbl_ent[b][i].state != ST_OBSOLETE) begin
                        tbl_ent[b][w] = tbl_ent[b][i];
                        w++;
                    end
                end
                f = w;
            end
            if (f >= QD) begin
                res.status = STS_FULL;
            end else begin
                st = ST_ACTIVE;
                for (int i = 0; i < f; i++) begin
                    if (tbl_ent[b][i].state == ST_OBSOLETE) continue;
                    if (tbl_ent[b][i].mode || r.exclusive) begin
                        st = ST_WAIT;
                        break;
                    end
                end
                e.state = st;
                e.mode = r.exclusive;
                e.txn = r.txn_id;
                tbl_ent[b][f] = e;
                f++;
                res.lock_state = st;
                res.status = STS_OK;
            end
        end else if (r.operation == OP_RELEASE) begin
            pos = QD;
            act_before = 0;
            for (int i = 0; i < f; i++) begin
                if (tbl_ent[b][i].state == ST_OBSOLETE) continue;
                if (tbl_ent[b][i].txn == r.txn_id) begin
                    pos = i;
                    break;
                end
                if (tbl_ent[b][i].state == ST_ACTIVE) act_before++;
            end
            if (pos < f) begin
                tbl_ent[b][pos].state = ST_OBSOLETE;
                if (act_before == 0) begin
                    shared_passed = 0;
                    for (int i = pos + 1; i < f; i++) begin
                        if (tbl_ent[b][i].state == ST_OBSOLETE) continue;
                        if (tbl_ent[b][i].mode) begin
                            if (shared_passed == 0) begin
                                if (tbl_ent[b][i].state == ST_WAIT) res.grant_count++;
                                tbl_ent[b][i].state = ST_ACTIVE;
                            end
                            break;
                        end
                        if (tbl_ent[b][i].state == ST_WAIT) res.grant_count++;
                        tbl_ent[b][i].state = ST_ACTIVE;
                        shared_passed++;
                    end
                end
                res.lock_state = ST_OBSOLETE;
                res.status = STS_OK;
            end
        end else if (r.operation == OP_CHECK) begin
            for (int i = 0; i < f; i++) begin
                if (tbl_ent[b][i].txn == r.txn_id) begin
                    res.lock_state = tbl_ent[b][i].state;
                    res.status = STS_OK;
                    break;
                end
            end
        end
        tbl_fill[b] = f;
        return res;
    endfunction

    function automatic t_req make_req(input logic [1:0] op, input logic [31:0] key,
                                      input logic [15:0] txn, input logic excl);
        t_req r;
        r.operation = op;
        r.lock_key = key;
        r.txn_id = txn;
        r.exclusive = excl;
        return r;
    endfunction

    // random key landing in one of nb buckets, with random upper bits
    function automatic logic [31:0] hot_key(input int nb);
        logic [31:0] k;
        k = $urandom;
        k[7:0] = 8'($urandom_range(0, nb - 1)) ^ 8'hA5;
        return k;
    endfunction

    // driver: bursts and gaps, holds payload until transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs[0];
                expected_rsps.push_back(lock_table_apply(pending_reqs.pop_front()));
                n_sent++;
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            i_ready <= 1'b0;
        end else if (n_sent == 300 && i_ready) begin
            stall_hold <= 400;
            i_ready <= 1'b0;
        end else if (n_sent > 600 && n_sent < 750) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare every response transfer
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected response, lock_state", o_rsp.lock_state, -1);
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.lock_state !== want.lock_state)
                    report_mismatch("lock_state", o_rsp.lock_state, want.lock_state);
                if (o_rsp.status !== want.status)
                    report_mismatch("status", o_rsp.status, want.status);
                if (o_rsp.grant_count !== want.grant_count)
                    report_mismatch("grant_count", o_rsp.grant_count, want.grant_count);
                if (want.status == STS_FULL) n_full++;
                if (want.lock_state == ST_WAIT) n_waits++;
                n_grants += want.grant_count;
                n_checked++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("reader_writer_lock_table_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // queue a well-formed run on one bucket: acquires, checks, releases
    task automatic add_lock_session(input int nb);
        logic [31:0] key;
        logic [15:0] txns[$];
        logic [15:0] t;
        int n;
        key = hot_key(nb);
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            t = 16'($urandom);
            txns.push_back(t);
            pending_reqs.push_back(make_req(OP_ACQUIRE, key, t, 1'($urandom_range(0, 1))));
        end
        txns.shuffle();
        foreach (txns[i]) begin
            if ($urandom_range(0, 2) == 0)
                pending_reqs.push_back(make_req(OP_CHECK, key, txns[i],
                                                1'($urandom_range(0, 1))));
            if ($urandom_range(0, 4) != 0)
                pending_reqs.push_back(make_req(OP_RELEASE, key, txns[i],
                                                1'($urandom_range(0, 1))));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_req = '0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_full = 0;
        n_grants = 0;
        n_waits = 0;
        stall_hold = 0;
        idle_cycles = 0;
        stim_done = 0;
        for (int b = 0; b < NB; b++) tbl_fill[b] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: shared grants, exclusive wait, full bucket, unknown ops
        pending_reqs.push_back(make_req(OP_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        pending_reqs.push_back(make_req(OP_RELEASE, 32'h0, 16'h0, 1'b0));
        pending_reqs.push_back(make_req(OP_ACQUIRE, 32'h0, 16'h0, 1'b0));
        pending_reqs.push_back(make_req(OP_ACQUIRE, 32'h100, 16'h1, 1'b1));
        pending_reqs.push_back(make_req(OP_ACQUIRE, 32'h200, 16'h2, 1'b0));
        pending_reqs.push_back(make_req(OP_ACQUIRE, 32'h300, 16'h3, 1'b0));
        pending_reqs.push_back(make_req(OP_ACQUIRE, 32'h400, 16'hFFFF, 1'b1));
        pending_reqs.push_back(make_req(OP_CHECK, 32'h500, 16'h1, 1'b0));
        pending_reqs.push_back(make_req(OP_RELEASE, 32'h0, 16'h0, 1'b1));
        pending_reqs.push_back(make_req(OP_RELEASE, 32'h0, 16'h1, 1'b0));
        pending_reqs.push_back(make_req(OP_CHECK, 32'h0, 16'h1, 1'b0));
        for (int i = 0; i < 5; i++)
            pending_reqs.push_back(make_req(OP_ACQUIRE, 32'hFFFF_FF00, 16'(16 + i), 1'b0));
        pending_reqs.push_back(make_req(OP_ACQUIRE, 32'h0, 16'h20, 1'b0));
        pending_reqs.push_back(make_req(OP_ACQUIRE, 32'h0, 16'h21, 1'b0));
        pending_reqs.push_back(make_req(OP_RELEASE, 32'h0, 16'h2, 1'b0));
        pending_reqs.push_back(make_req(OP_ACQUIRE, 32'h0, 16'h22, 1'b1));
        pending_reqs.push_back(make_req(OP_ACQUIRE, 32'hFF, 16'h23, 1'b0));
        pending_reqs.push_back(make_req(2'd3, 32'h0, 16'h0, 1'b1));
        pending_reqs.push_back(make_req(OP_CHECK, 32'h7F, 16'h8000, 1'b0));

        // pause until the block has drained everything
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (40) @(posedge i_clk);

        // random: mostly sessions on a few hot buckets, some noise
        while (n_sent + pending_reqs.size() < 1050) begin
            if ($urandom_range(0, 9) < 8) begin
                add_lock_session(($urandom_range(0, 3) == 0) ? 256 : 4);
            end else begin
                pending_reqs.push_back(make_req(2'($urandom_range(0, 3)), hot_key(8),
                                                16'($urandom_range(0, 15)),
                                                1'($urandom_range(0, 1))));
            end
            wait (pending_reqs.size() < 30);
        end
        stim_done = 1;

        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d requests, %0d waits, %0d grants, %0d full refusals.",
                 n_checked, n_waits, n_grants, n_full);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("reader_writer_lock_table_core: match");
        end else begin
            $display("reader_writer_lock_table_core: mismatch");
        end
        $finish;
    end

endmodule

/* reader_writer_lock_table_core.f */
rtl/core/rwlt_pkg.sv
rtl/core/rwlt_ram.sv
rtl/core/reader_writer_lock_table_core.sv
verif/reader_writer_lock_table_core_tb.sv
